// ===== rtl/core/cpc_pkg.sv =====
package cpc_pkg;

  localparam int CACHE_DEPTH   = 1021;
  localparam int PALETTE_DEPTH = 256;
  localparam int CACHE_AW      = $clog2(CACHE_DEPTH);
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int PAL_CNT_W     = $clog2(PALETTE_DEPTH + 1);
  localparam int CIU_W         = 9;
  localparam int COLOR_W       = 24;
  localparam int INDEX_W       = 8;
  localparam int CHAN_W        = 8;
  localparam int SQ_W          = 2 * CHAN_W;
  localparam int DIST_W        = 18;
  localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(195076);

  // color mod CACHE_DEPTH by folding: weights are 2^16 and 2^8 reduced
  localparam int FOLD_SUM_W = 17;
  localparam int FOLD_Z_W   = CACHE_AW + 1;
  localparam logic [FOLD_SUM_W-1:0] RED_WEIGHT   = FOLD_SUM_W'((1 << 16) % CACHE_DEPTH);
  localparam logic [FOLD_SUM_W-1:0] GREEN_WEIGHT = FOLD_SUM_W'((1 << 8) % CACHE_DEPTH);
  localparam logic [FOLD_Z_W-1:0]   FOLD_WEIGHT  = FOLD_Z_W'((1 << CACHE_AW) % CACHE_DEPTH);
  localparam logic [FOLD_Z_W-1:0]   SLOT_LIMIT   = FOLD_Z_W'(CACHE_DEPTH);
  localparam logic [CACHE_AW-1:0]   SWEEP_LAST   = CACHE_AW'(CACHE_DEPTH - 1);

  typedef enum logic [1:0] {
    KIND_CONVERT     = 2'd0,
    KIND_PAL_WRITE   = 2'd1,
    KIND_INVAL_INDEX = 2'd2,
    KIND_INVAL_ALL   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [INDEX_W-1:0] palette_index;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] color_index;
    logic               hit;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [COLOR_W-1:0] color;
    logic [INDEX_W-1:0] index;
  } cache_entry_t;

  typedef enum logic [3:0] {
    ST_RESET_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_SLOT,
    ST_LOOKUP,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_FILL,
    ST_PAL_WR,
    ST_INVAL,
    ST_INVAL_DRAIN,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic cache_rd_slot;
    logic hit_take;
    logic scan_issue;
    logic cache_fill;
    logic pal_write;
    logic clear_step;
    logic inval_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_hit;
    logic scan_end;
    logic scan_busy;
    logic sweep_last;
  } dp_status_t;

endpackage

// ===== rtl/core/cpc_ram.sv =====
module cpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cpc_ctrl.sv =====
module cpc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic [1:0]          item_kind,
  output logic                item_stall,
  output logic                result_valid,
  input  logic                result_stall,
  output cpc_pkg::ctrl_cmd_t  cmd,
  input  cpc_pkg::dp_status_t status
);

  import cpc_pkg::*;

  state_t state;
  state_t state_next;
  logic   result_valid_next;
  logic   out_free;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RESET_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RESET_CLEAR: if (status.sweep_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (item_valid) begin
          case (item_kind)
            KIND_CONVERT:     state_next = ST_HASH;
            KIND_PAL_WRITE:   state_next = ST_PAL_WR;
            KIND_INVAL_INDEX: state_next = ST_INVAL;
            KIND_INVAL_ALL:   state_next = ST_CLEAR;
            default:          state_next = ST_IDLE;
          endcase
        end
      end
      ST_HASH:   state_next = ST_SLOT;
      ST_SLOT:   state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_CHECK;
      ST_CHECK:  state_next = status.is_hit ? ST_FINISH : ST_SCAN;
      ST_SCAN:   if (status.scan_end) state_next = ST_DRAIN;
      ST_DRAIN:  if (!status.scan_busy) state_next = ST_FILL;
      ST_FILL:   state_next = ST_FINISH;
      ST_PAL_WR: state_next = ST_FINISH;
      ST_INVAL:  if (status.sweep_last) state_next = ST_INVAL_DRAIN;
      ST_INVAL_DRAIN: state_next = ST_FINISH;
      ST_CLEAR:  if (status.sweep_last) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd               = '0;
    item_stall        = 1'b1;
    result_valid_next = result_valid && result_stall;
    case (state)
      ST_RESET_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        item_stall  = 1'b0;
        cmd.capture = item_valid;
      end
      ST_LOOKUP: cmd.cache_rd_slot = 1'b1;
      ST_CHECK:  cmd.hit_take = status.is_hit;
      ST_SCAN:   cmd.scan_issue = !status.scan_end;
      ST_FILL:   cmd.cache_fill = 1'b1;
      ST_PAL_WR: cmd.pal_write = 1'b1;
      ST_INVAL:  cmd.inval_step = 1'b1;
      ST_CLEAR:  cmd.clear_step = 1'b1;
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load      = 1'b1;
          result_valid_next = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/cpc_datapath.sv =====
module cpc_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  cpc_pkg::item_t           item,
  input  logic                     cfg_valid,
  input  logic [cpc_pkg::CIU_W-1:0] cfg_data,
  input  cpc_pkg::ctrl_cmd_t       cmd,
  output cpc_pkg::dp_status_t      status,
  output cpc_pkg::result_t         result
);

  import cpc_pkg::*;

  item_t                   item_r;
  logic [CIU_W-1:0]        colors_in_use;
  logic [PAL_CNT_W-1:0]    n_sat;
  logic [COLOR_W-1:0]      colour;
  logic [FOLD_SUM_W-1:0]   fold_sum;
  logic [FOLD_Z_W-1:0]     fold_z;
  logic [CACHE_AW-1:0]     slot;

  logic [PAL_CNT_W-1:0]    scan_cnt;
  logic                    v_rd;
  logic                    v_sq;
  logic [INDEX_W-1:0]      idx_rd;
  logic [INDEX_W-1:0]      idx_sq;
  logic [SQ_W-1:0]         sq_r;
  logic [SQ_W-1:0]         sq_g;
  logic [SQ_W-1:0]         sq_b;
  logic [DIST_W-1:0]       dist_sum;
  logic [DIST_W-1:0]       best;
  logic [INDEX_W-1:0]      found;

  logic [CACHE_AW-1:0]     sweep_cnt;
  logic                    inv_pend;
  logic [CACHE_AW-1:0]     inv_addr;
  logic                    inv_wb;

  logic [INDEX_W-1:0]      ans_index;
  logic                    ans_hit;

  logic                    pal_we;
  logic [COLOR_W-1:0]      pal_rdata;
  logic [CHAN_W-1:0]       d_r;
  logic [CHAN_W-1:0]       d_g;
  logic [CHAN_W-1:0]       d_b;

  logic                    c_we;
  logic [CACHE_AW-1:0]     c_waddr;
  cache_entry_t            c_wdata;
  logic                    c_re;
  logic [CACHE_AW-1:0]     c_raddr;
  cache_entry_t            c_rdata;

  assign colour = {item_r.red, item_r.green, item_r.blue};
  assign n_sat  = (colors_in_use > CIU_W'(PALETTE_DEPTH)) ? PAL_CNT_W'(PALETTE_DEPTH)
                                                          : PAL_CNT_W'(colors_in_use);
  assign slot   = (fold_z >= SLOT_LIMIT) ? CACHE_AW'(fold_z - SLOT_LIMIT)
                                         : fold_z[CACHE_AW-1:0];

  // palette
  assign pal_we = cmd.pal_write && ({1'b0, item_r.palette_index} < (INDEX_W + 1)'(PALETTE_DEPTH));

  cpc_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_DEPTH)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (item_r.palette_index[PAL_AW-1:0]),
    .wdata (colour),
    .re    (cmd.scan_issue),
    .raddr (scan_cnt[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  assign d_r = (item_r.red >= pal_rdata[23:16]) ? item_r.red - pal_rdata[23:16]
                                                 : pal_rdata[23:16] - item_r.red;
  assign d_g = (item_r.green >= pal_rdata[15:8]) ? item_r.green - pal_rdata[15:8]
                                                  : pal_rdata[15:8] - item_r.green;
  assign d_b = (item_r.blue >= pal_rdata[7:0]) ? item_r.blue - pal_rdata[7:0]
                                                : pal_rdata[7:0] - item_r.blue;
  assign dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  // cache
  assign inv_wb = inv_pend && c_rdata.valid && (c_rdata.index == item_r.palette_index);
  assign c_re    = cmd.cache_rd_slot || cmd.inval_step;
  assign c_raddr = cmd.inval_step ? sweep_cnt : slot;

  always_comb begin
    c_we    = 1'b0;
    c_waddr = sweep_cnt;
    c_wdata = '0;
    if (cmd.clear_step) begin
      c_we = 1'b1;
    end else if (cmd.cache_fill) begin
      c_we    = 1'b1;
      c_waddr = slot;
      c_wdata = '{valid: 1'b1, color: colour, index: found};
    end else if (inv_wb) begin
      c_we    = 1'b1;
      c_waddr = inv_addr;
    end
  end

  cpc_ram #(.WIDTH($bits(cache_entry_t)), .DEPTH(CACHE_DEPTH)) u_cache (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (c_re),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  assign status.is_hit     = c_rdata.valid && (c_rdata.color == colour);
  assign status.scan_end   = (scan_cnt == n_sat);
  assign status.scan_busy  = v_rd || v_sq;
  assign status.sweep_last = (sweep_cnt == SWEEP_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      colors_in_use <= '0;
      scan_cnt      <= '0;
      sweep_cnt     <= '0;
      v_rd          <= 1'b0;
      v_sq          <= 1'b0;
      inv_pend      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        colors_in_use <= cfg_data;
      end
      if (cmd.capture) begin
        scan_cnt <= '0;
      end else if (cmd.scan_issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (cmd.capture) begin
        sweep_cnt <= '0;
      end else if (cmd.clear_step || cmd.inval_step) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end
      v_rd     <= cmd.scan_issue;
      v_sq     <= v_rd;
      inv_pend <= cmd.inval_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r    <= item;
      ans_index <= '0;
      ans_hit   <= 1'b0;
      best      <= DIST_BOUND;
      found     <= '0;
    end
    fold_sum <= FOLD_SUM_W'(item_r.red) * RED_WEIGHT
              + FOLD_SUM_W'(item_r.green) * GREEN_WEIGHT
              + FOLD_SUM_W'(item_r.blue);
    fold_z   <= FOLD_WEIGHT * FOLD_Z_W'(fold_sum[FOLD_SUM_W-1:CACHE_AW])
              + FOLD_Z_W'(fold_sum[CACHE_AW-1:0]);
    idx_rd   <= scan_cnt[INDEX_W-1:0];
    idx_sq   <= idx_rd;
    sq_r     <= d_r * d_r;
    sq_g     <= d_g * d_g;
    sq_b     <= d_b * d_b;
    inv_addr <= sweep_cnt;
    if (v_sq && (dist_sum < best)) begin
      best  <= dist_sum;
      found <= idx_sq;
    end
    if (cmd.hit_take) begin
      ans_index <= c_rdata.index;
      ans_hit   <= 1'b1;
    end
    if (cmd.cache_fill) begin
      ans_index <= found;
      ans_hit   <= 1'b0;
    end
    if (cmd.out_load) begin
      result <= '{color_index: ans_index, hit: ans_hit};
    end
  end

endmodule

// ===== rtl/core/cached_nearest_palette_color_unit.sv =====
// Nearest palette color lookup with a direct-mapped result cache.
// Input channel item_valid/item_stall carries one word of type item_t:
// convert a color, write a palette entry, drop cached entries holding an
// index, or drop the whole cache. Every word yields one result word on
// result_valid/result_stall (color_index and hit; zero for non-convert words).
// Config channel cfg_valid/cfg_ready writes colors_in_use; cfg_ready is
// always high. Write it only while the unit is idle.
// A convert word is hashed to a cache slot and the slot is read; a hit
// returns the cached index, a miss scans N palette entries (N =
// colors_in_use, capped at 256; one palette read and one distance per
// cycle), drains the distance pipeline and fills the slot. Dropping by
// index or the whole cache sweeps one cache slot per cycle over 1021 slots.
// One word is in work at a time; the next word may be taken in the cycle
// after the previous one reaches the output register.
// Reset clears the control state and then sweeps all 1021 cache slots,
// holding item_stall high until the sweep is done. A stalled result
// holds in the output register; one more word may be accepted and worked on
// meanwhile.
module cached_nearest_palette_color_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  cpc_pkg::item_t            item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output cpc_pkg::result_t          result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cpc_pkg::CIU_W-1:0] cfg_data
);

  import cpc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  cpc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_kind    (item.kind),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .status       (status)
  );

  cpc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
